### design/rpn_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the RPN evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int DIG_W       = 4;
    localparam int STAT_W      = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_EQUALS = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_READY     = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIVZERO   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu;

    typedef struct packed {
        logic    push;
        logic    clear;
        logic    rd_next;
        logic    cap_right;
        logic    cap_left;
        logic    res_load;
        t_alu    alu;
        logic    div_start;
        logic    write_res;
        logic    emit;
        t_status emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic lt2;
        logic full;
        logic rzero;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

### design/rpn_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the token input and the result output.
interface rpn_in_if import rpn_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [DIG_W-1:0] digit;

    modport source (output valid, output opcode, output digit, input ready);
    modport sink   (input valid, input opcode, input digit, output ready);
endinterface

interface rpn_out_if import rpn_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

### design/rpn_div.sv
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpn_div import rpn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_q;
    logic [DATA_W-1:0]    r_d;
    logic                 r_neg;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      diff;

    assign rem_sh = {r_rem, r_q[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_d   <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_cnt <= DIV_CNT_W'(DATA_W - 1);
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_q) : r_q;

endmodule

### design/rpn_dp.sv
`timescale 1ns / 1ps
// Datapath: operand stack memory, stack count, ALU, divider and result register.
module rpn_dp import rpn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [DIG_W-1:0]         i_digit,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_value,
    output t_dp_stat                 o_stat
);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] n_res;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] div_quot;
    logic              div_done;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_value;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign cnt_m2  = r_count - CNT_W'(2);
    assign rd_addr = i_cmd.rd_next ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    assign wr_en   = i_cmd.push || i_cmd.write_res;
    assign wr_addr = i_cmd.push ? r_count[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
    assign wr_data = i_cmd.push ? DATA_W'(i_digit) : r_res;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.write_res) begin
            r_count <= cnt_m1;
        end
    end

    assign mul_lo = r_left * r_right;

    always_comb begin
        unique case (i_cmd.alu)
            ALU_ADD: n_res = r_left + r_right;
            ALU_SUB: n_res = r_left - r_right;
            ALU_MUL: n_res = mul_lo;
            ALU_DIV: n_res = div_quot;
            default: n_res = r_left + r_right;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_right) begin
            r_right <= r_rd;
        end
        if (i_cmd.cap_left) begin
            r_left <= r_rd;
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
    end

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_left),
        .i_divisor  (r_right),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_value  <= (i_cmd.emit_status == ST_READY) ? r_right : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.lt2      = (r_count < CNT_W'(2));
    assign o_stat.full     = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.rzero    = (r_right == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

### design/rpn_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences each token through the datapath.
module rpn_ctrl import rpn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_opcode,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_NEXT,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_opcode r_op;
    t_opcode n_op;
    t_status r_status;
    t_status n_status;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_PUSH;
            r_status <= ST_ACCEPTED;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        o_cmd    = '0;

        unique case (r_op)
            OP_SUB:  o_cmd.alu = ALU_SUB;
            OP_MUL:  o_cmd.alu = ALU_MUL;
            OP_DIV:  o_cmd.alu = ALU_DIV;
            default: o_cmd.alu = ALU_ADD;
        endcase
        o_cmd.emit_status = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_opcode'(i_opcode);
                    n_state = S_EMIT;
                    unique case (t_opcode'(i_opcode))
                        OP_PUSH: begin
                            if (i_stat.full) begin
                                o_cmd.clear = 1'b1;
                                n_status    = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                                n_status   = ST_ACCEPTED;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (i_stat.lt2) begin
                                o_cmd.clear = 1'b1;
                                n_status    = ST_UNDERFLOW;
                            end else begin
                                n_state = S_RD_TOP;
                            end
                        end
                        OP_EQUALS: begin
                            if (i_stat.empty) begin
                                o_cmd.clear = 1'b1;
                                n_status    = ST_UNDERFLOW;
                            end else begin
                                n_state = S_RD_TOP;
                            end
                        end
                        default: begin
                            n_status = ST_ACCEPTED;
                        end
                    endcase
                end
            end
            S_RD_TOP: begin
                o_cmd.cap_right = 1'b1;
                if (r_op == OP_EQUALS) begin
                    o_cmd.clear = 1'b1;
                    n_status    = ST_READY;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_RD_NEXT;
                end
            end
            S_RD_NEXT: begin
                o_cmd.cap_left = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_DIV) begin
                    if (i_stat.rzero) begin
                        o_cmd.clear = 1'b1;
                        n_status    = ST_DIVZERO;
                        n_state     = S_EMIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_res = 1'b1;
                n_status        = ST_ACCEPTED;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/rpn_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Top level of the RPN evaluator: one token item in, one result item out.
// Push, unknown codes and early errors go straight to emit; equals first reads the top; a
// zero divisor emits after both reads; add, subtract and multiply execute and write back;
// divide first runs the divider. Ready returns on the edge that loads the result.
// A stalled result lets one more token in; that token waits to emit and holds off the input.
// Synchronous active-low reset clears the stack count, controller and output valid; stack
// memory contents are not cleared and need no clearing pass.
module rpn_stack_evaluator_top import rpn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpn_in_if.sink    i_tok,
    rpn_out_if.source o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_tok.ready = in_ready;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .o_in_ready (in_ready),
        .i_opcode   (i_tok.opcode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rpn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_digit     (i_tok.digit),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_status    (o_res.status),
        .o_value     (o_res.value),
        .o_stat      (stat)
    );

endmodule

### design/rpn_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the RPN evaluator, bound to the top level.
module rpn_checker import rpn_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [DATA_W-1:0] i_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_READY |-> i_value == '0)
        else $error("nonzero value without ready status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_ACCEPTED || i_status == ST_READY ||
                         i_status == ST_UNDERFLOW || i_status == ST_OVERFLOW ||
                         i_status == ST_DIVZERO))
        else $error("illegal status code");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("token taken while another is in flight");

endmodule

bind rpn_stack_evaluator_top rpn_checker u_rpn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tok.valid),
    .i_in_ready  (i_tok.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_value     (o_res.value)
);
